>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PIDV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define PIDV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define PIDV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pidv_pkg.sv
// ----------------------------------------------------------------------------
// PID with variable integral: shared package
// Widths, register codes, reset values, controller states and multiplier types.
// ----------------------------------------------------------------------------
package pidv_pkg;

	localparam int VALUE_W  = 32;
	localparam int INTEG_W  = 48;
	localparam int GAIN_W   = 20;
	localparam int RECIP_W  = 16;
	localparam int FRAC_W   = 16;
	localparam int WEIGHT_W = FRAC_W + 1;
	localparam int DIFF_W   = VALUE_W + 1;
	localparam int ACC_W    = INTEG_W + 6;

	localparam int DIGIT_W  = 4;
	localparam int MR_W     = GAIN_W;
	localparam int MC_W     = INTEG_W + 5;
	localparam int PROD_W   = MC_W + MR_W;
	localparam int NDIG     = (MR_W + DIGIT_W - 1) / DIGIT_W;
	localparam int CNT_W    = $clog2(NDIG);

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1) << FRAC_W;

	localparam logic [GAIN_W-1:0]         PROP_GAIN_RST  = GAIN_W'(13107);
	localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST = GAIN_W'(6554);
	localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST = GAIN_W'(13107);
	localparam logic signed [VALUE_W-1:0] SEP_HIGH_RST   = VALUE_W'(13107200);
	localparam logic signed [VALUE_W-1:0] SEP_LOW_RST    = VALUE_W'(11796480);
	localparam logic [RECIP_W-1:0]        RAMP_RECIP_RST = RECIP_W'(3277);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_SEP_HIGH   = 3'd3,
		REG_SEP_LOW    = 3'd4,
		REG_RAMP_RECIP = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERROR,
		ST_CLASSIFY,
		ST_MUL_W,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I1,
		ST_MUL_I,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [MC_W-1:0]        mcand;
		logic [MR_W-1:0]        mplier;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

>>> rtl/pidv_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed multiplicand times unsigned multiplier, one four-bit digit per cycle.
// ----------------------------------------------------------------------------
module pidv_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidv_pkg::mul_req_t                    req,
	output pidv_pkg::mul_stat_t                   stat,
	output logic signed [pidv_pkg::PROD_W-1:0]    product
);

	logic signed [pidv_pkg::PROD_W-1:0] mc_q;
	logic signed [pidv_pkg::PROD_W-1:0] prod_q;
	logic signed [pidv_pkg::PROD_W-1:0] pp;
	logic [pidv_pkg::MR_W-1:0]          mr_q;
	logic [pidv_pkg::CNT_W-1:0]         cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic                               last;

	assign pp   = mc_q * $signed({1'b0, mr_q[pidv_pkg::DIGIT_W-1:0]});
	assign last = (cnt_q == pidv_pkg::CNT_W'(pidv_pkg::NDIG - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + pidv_pkg::CNT_W'(1);
			done_q <= last;
			if (last) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mc_q   <= {{(pidv_pkg::PROD_W - pidv_pkg::MC_W){req.mcand[pidv_pkg::MC_W-1]}},
				req.mcand};
			mr_q   <= req.mplier;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + pp;
			mc_q   <= mc_q <<< pidv_pkg::DIGIT_W;
			mr_q   <= mr_q >> pidv_pkg::DIGIT_W;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = prod_q;

endmodule

>>> rtl/pid_variable_integral_unit.sv
// ----------------------------------------------------------------------------
// PID controller with variable integral weight
// Positional PID on a unity simulated plant, Q16.16 values and Q4.16 gains.
// ----------------------------------------------------------------------------
// Each transaction on the s_axis channel carries a setpoint; the block answers
// with exactly one drive value on the m_axis channel. The error is the setpoint
// minus the previous drive. The integral weight is zero above sep_high, one
// below sep_low and ramps in between; the integral and the drive saturate.
// The user must set gains and thresholds through the APB port only while the
// block is idle; the block itself does not enforce this. A new setpoint is
// accepted only in the idle state, after the previous one has been worked
// through. One shared multiplier handles four multiplier bits per cycle and
// makes four or five passes, for the proportional, derivative, two integral
// products and the ramp weight; the ramp weight pass runs only when the
// error lies in the ramp band.
// Reset loads the default gains and thresholds and clears the measurement,
// previous error and integral. A finished drive waits in an output register;
// the next setpoint is accepted meanwhile and its result is held back until
// the receiver has taken the earlier one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_variable_integral_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [pidv_pkg::VALUE_W-1:0]          s_axis_tdata,  // [31:0] setpoint
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [pidv_pkg::VALUE_W-1:0]          m_axis_tdata,  // [31:0] drive
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pidv_pkg::ADDR_W-1:0]           paddr,
	input  logic [pidv_pkg::DATA_W-1:0]           pwdata,
	output logic [pidv_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	localparam int VW = pidv_pkg::VALUE_W;
	localparam int IW = pidv_pkg::INTEG_W;
	localparam int AW = pidv_pkg::ACC_W;
	localparam int FW = pidv_pkg::FRAC_W;
	localparam int MW = pidv_pkg::MC_W;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

	logic [pidv_pkg::GAIN_W-1:0]         prop_gain_q;
	logic [pidv_pkg::GAIN_W-1:0]         integ_gain_q;
	logic [pidv_pkg::GAIN_W-1:0]         deriv_gain_q;
	logic signed [VW-1:0]                sep_high_q;
	logic signed [VW-1:0]                sep_low_q;
	logic [pidv_pkg::RECIP_W-1:0]        ramp_recip_q;

	logic signed [VW-1:0]                measured_q;
	logic signed [VW-1:0]                prev_error_q;
	logic signed [IW-1:0]                integ_q;

	logic signed [VW-1:0]                setpoint_q;
	logic signed [VW-1:0]                e_q;
	logic [pidv_pkg::WEIGHT_W-1:0]       w_q;
	logic signed [AW-1:0]                acc_q;
	logic signed [MW-1:0]                i1_q;
	logic                                m_tvalid_q;
	logic [VW-1:0]                       m_tdata_q;

	pidv_pkg::state_t                    state_q;
	pidv_pkg::state_t                    state_d;

	pidv_pkg::mul_req_t                  mul_req;
	pidv_pkg::mul_stat_t                 mul_stat;
	logic signed [pidv_pkg::PROD_W-1:0]  product;

	logic                                cfg_wr;
	logic                                in_accept;
	logic                                out_free;
	logic                                out_load;
	logic                                in_mul;
	logic                                above;
	logic                                below;

	logic signed [pidv_pkg::DIFF_W-1:0]  err_diff;
	logic signed [VW-1:0]                err_sat;
	logic signed [IW:0]                  integ_sum;
	logic signed [IW-1:0]                integ_sat;
	logic signed [pidv_pkg::DIFF_W-1:0]  ramp_op;
	logic signed [pidv_pkg::DIFF_W-1:0]  deriv_op;
	logic [VW-1:0]                       w_raw;
	logic signed [AW-1:0]                term;
	logic signed [VW-1:0]                drive;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= pidv_pkg::PROP_GAIN_RST;
			integ_gain_q <= pidv_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= pidv_pkg::DERIV_GAIN_RST;
			sep_high_q   <= pidv_pkg::SEP_HIGH_RST;
			sep_low_q    <= pidv_pkg::SEP_LOW_RST;
			ramp_recip_q <= pidv_pkg::RAMP_RECIP_RST;
		end else if (cfg_wr) begin
			case (pidv_pkg::reg_idx_t'(paddr[pidv_pkg::ADDR_W-1:2]))
				pidv_pkg::REG_PROP_GAIN:  prop_gain_q  <= pwdata[pidv_pkg::GAIN_W-1:0];
				pidv_pkg::REG_INTEG_GAIN: integ_gain_q <= pwdata[pidv_pkg::GAIN_W-1:0];
				pidv_pkg::REG_DERIV_GAIN: deriv_gain_q <= pwdata[pidv_pkg::GAIN_W-1:0];
				pidv_pkg::REG_SEP_HIGH:   sep_high_q   <= pwdata[VW-1:0];
				pidv_pkg::REG_SEP_LOW:    sep_low_q    <= pwdata[VW-1:0];
				pidv_pkg::REG_RAMP_RECIP: ramp_recip_q <= pwdata[pidv_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pidv_pkg::reg_idx_t'(paddr[pidv_pkg::ADDR_W-1:2]))
			pidv_pkg::REG_PROP_GAIN:  prdata = pidv_pkg::DATA_W'(prop_gain_q);
			pidv_pkg::REG_INTEG_GAIN: prdata = pidv_pkg::DATA_W'(integ_gain_q);
			pidv_pkg::REG_DERIV_GAIN: prdata = pidv_pkg::DATA_W'(deriv_gain_q);
			pidv_pkg::REG_SEP_HIGH:   prdata = pidv_pkg::DATA_W'(sep_high_q);
			pidv_pkg::REG_SEP_LOW:    prdata = pidv_pkg::DATA_W'(sep_low_q);
			pidv_pkg::REG_RAMP_RECIP: prdata = pidv_pkg::DATA_W'(ramp_recip_q);
			default:                  prdata = '0;
		endcase
	end

	// Error, classification and integral update.
	assign err_diff = {setpoint_q[VW-1], setpoint_q} - {measured_q[VW-1], measured_q};
	assign err_sat  = (err_diff[VW] != err_diff[VW-1]) ? (err_diff[VW] ? VMIN : VMAX)
		: err_diff[VW-1:0];

	assign above = (e_q > sep_high_q);
	assign below = (e_q < sep_low_q);

	assign integ_sum = {integ_q[IW-1], integ_q} + {{(IW+1-VW){e_q[VW-1]}}, e_q};
	assign integ_sat = (integ_sum[IW] != integ_sum[IW-1]) ? (integ_sum[IW] ? IMIN : IMAX)
		: integ_sum[IW-1:0];

	assign ramp_op  = {sep_high_q[VW-1], sep_high_q} - {e_q[VW-1], e_q};
	assign deriv_op = {e_q[VW-1], e_q} - {prev_error_q[VW-1], prev_error_q};

	assign w_raw = product[FW +: VW];
	assign term  = product[FW +: AW];

	assign drive = (&acc_q[AW-1:VW-1] || ~|acc_q[AW-1:VW-1]) ? acc_q[VW-1:0]
		: (acc_q[AW-1] ? VMIN : VMAX);

	assign out_free = !m_tvalid_q || m_axis_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidv_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = pidv_pkg::ST_ERROR;
				end
			end
			pidv_pkg::ST_ERROR:    state_d = pidv_pkg::ST_CLASSIFY;
			pidv_pkg::ST_CLASSIFY: state_d = (above || below) ? pidv_pkg::ST_MUL_P
				: pidv_pkg::ST_MUL_W;
			pidv_pkg::ST_MUL_W: begin
				if (mul_stat.done) begin
					state_d = pidv_pkg::ST_MUL_P;
				end
			end
			pidv_pkg::ST_MUL_P: begin
				if (mul_stat.done) begin
					state_d = pidv_pkg::ST_MUL_D;
				end
			end
			pidv_pkg::ST_MUL_D: begin
				if (mul_stat.done) begin
					state_d = pidv_pkg::ST_MUL_I1;
				end
			end
			pidv_pkg::ST_MUL_I1: begin
				if (mul_stat.done) begin
					state_d = pidv_pkg::ST_MUL_I;
				end
			end
			pidv_pkg::ST_MUL_I: begin
				if (mul_stat.done) begin
					state_d = pidv_pkg::ST_SUM;
				end
			end
			pidv_pkg::ST_SUM: begin
				if (out_free) begin
					state_d = pidv_pkg::ST_IDLE;
				end
			end
			default: state_d = pidv_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs and multiplier operands.
	always_comb begin
		s_axis_tready  = 1'b0;
		out_load       = 1'b0;
		in_mul         = 1'b0;
		mul_req.mcand  = '0;
		mul_req.mplier = '0;
		case (state_q)
			pidv_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pidv_pkg::ST_MUL_W: begin
				in_mul         = 1'b1;
				mul_req.mcand  = MW'(ramp_op);
				mul_req.mplier = pidv_pkg::MR_W'(ramp_recip_q);
			end
			pidv_pkg::ST_MUL_P: begin
				in_mul         = 1'b1;
				mul_req.mcand  = MW'(e_q);
				mul_req.mplier = prop_gain_q;
			end
			pidv_pkg::ST_MUL_D: begin
				in_mul         = 1'b1;
				mul_req.mcand  = MW'(deriv_op);
				mul_req.mplier = deriv_gain_q;
			end
			pidv_pkg::ST_MUL_I1: begin
				in_mul         = 1'b1;
				mul_req.mcand  = MW'(integ_q);
				mul_req.mplier = integ_gain_q;
			end
			pidv_pkg::ST_MUL_I: begin
				in_mul         = 1'b1;
				mul_req.mcand  = i1_q;
				mul_req.mplier = pidv_pkg::MR_W'(w_q);
			end
			pidv_pkg::ST_SUM: out_load = out_free;
			default: ;
		endcase
		mul_req.start = in_mul && !mul_stat.busy && !mul_stat.done;
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Controller state carried from one setpoint to the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measured_q   <= '0;
			prev_error_q <= '0;
			integ_q      <= '0;
		end else begin
			if (state_q == pidv_pkg::ST_CLASSIFY && !above) begin
				integ_q <= integ_sat;
			end
			if (out_load) begin
				measured_q   <= drive;
				prev_error_q <= e_q;
			end
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			setpoint_q <= s_axis_tdata;
		end
		if (state_q == pidv_pkg::ST_ERROR) begin
			e_q <= err_sat;
		end
		if (state_q == pidv_pkg::ST_CLASSIFY) begin
			w_q <= above ? '0 : pidv_pkg::ONE_Q16;
		end
		if (mul_stat.done) begin
			case (state_q)
				pidv_pkg::ST_MUL_W: w_q <= (w_raw > VW'(pidv_pkg::ONE_Q16)) ? pidv_pkg::ONE_Q16
					: w_raw[pidv_pkg::WEIGHT_W-1:0];
				pidv_pkg::ST_MUL_P:  acc_q <= term;
				pidv_pkg::ST_MUL_D:  acc_q <= acc_q + term;
				pidv_pkg::ST_MUL_I1: i1_q  <= product[FW +: MW];
				pidv_pkg::ST_MUL_I:  acc_q <= acc_q + term;
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= drive;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	pidv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.stat    (mul_stat),
		.product (product)
	);

	`PIDV_ASSERT_IMP(a_mul_start_free, mul_req.start, !mul_stat.busy, "multiplier restarted while busy")
	`PIDV_ASSERT_IMP(a_out_no_overwrite, out_load, !m_tvalid_q || m_axis_tready, "pending drive overwritten")
	`PIDV_ASSERT_NEXT(a_integ_frozen, (state_q == pidv_pkg::ST_CLASSIFY) && above, $stable(integ_q), "integral moved above threshold")
	`PIDV_ASSERT_IMP(a_weight_max, state_q == pidv_pkg::ST_MUL_I, w_q <= pidv_pkg::ONE_Q16, "integral weight above one")

endmodule
